// ===== sv/slnc_pkg.sv =====
// shared types, constants and helper functions of the nested-comment source lexer
`default_nettype none

package slnc_pkg;

  // sizing
  localparam int MAX_LEXEME        = 256;
  localparam int MAX_COMMENT_DEPTH = 255;
  localparam int LEX_W             = $clog2(MAX_LEXEME + 1);
  localparam int DEPTH_W           = $clog2(MAX_COMMENT_DEPTH + 1);
  localparam int LINE_W            = 16;
  localparam int COL_W             = 8;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  // scanner modes
  typedef enum logic [3:0] {
    M_IDLE          = 4'd0,
    M_PIPE          = 4'd1,
    M_LINE          = 4'd2,
    M_BLOCK         = 4'd3,
    M_BLOCK_PIPE    = 4'd4,
    M_BLOCK_BRACKET = 4'd5,
    M_IDENT         = 4'd6,
    M_STRING        = 4'd7,
    M_STRING_ESC    = 4'd8,
    M_ENDED         = 4'd9
  } mode_t;

  // token kinds
  localparam logic [3:0] KIND_IDENT   = 4'd0;
  localparam logic [3:0] KIND_STRING  = 4'd1;
  localparam logic [3:0] KIND_END     = 4'd2;
  localparam logic [3:0] KIND_UNKNOWN = 4'd3;
  localparam logic [3:0] KIND_KW_BASE = 4'd4;
  localparam logic [3:0] KIND_COMMA   = 4'd8;
  localparam logic [3:0] KIND_DOT     = 4'd9;
  localparam logic [3:0] KIND_LBRACE  = 4'd10;
  localparam logic [3:0] KIND_RBRACE  = 4'd11;
  localparam logic [3:0] KIND_LPAREN  = 4'd12;
  localparam logic [3:0] KIND_RPAREN  = 4'd13;
  localparam logic [3:0] KIND_PLUS    = 4'd14;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd1;
  localparam logic [2:0] ERR_OPEN_STRING = 3'd2;
  localparam logic [2:0] ERR_OPEN_COMMENT = 3'd3;
  localparam logic [2:0] ERR_PAST_END    = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG    = 3'd5;
  localparam logic [2:0] ERR_TOO_DEEP    = 3'd6;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // keyword slots
  localparam logic [1:0] KW_CRISP     = 2'd0;
  localparam logic [1:0] KW_MAINCRISP = 2'd1;
  localparam logic [1:0] KW_BITE      = 2'd2;
  localparam logic [1:0] KW_ENDL      = 2'd3;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_line;
    logic       end_of_program;
  } item_t;

  typedef struct packed {
    logic [7:0]        lexeme_char;
    logic              char_valid;
    logic              token_done;
    logic [3:0]        token_kind;
    logic [LINE_W-1:0] start_line;
    logic [COL_W-1:0]  start_column;
    logic [2:0]        error_code;
  } result_t;

  // up to two results caused by one request
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic halted;
    logic push;
  } front_status_t;

  function automatic result_t mk_result(input logic [7:0] ch, input logic valid,
                                        input logic done, input logic [3:0] kind,
                                        input logic [LINE_W-1:0] line,
                                        input logic [COL_W-1:0] col,
                                        input logic [2:0] err);
    result_t r;
    r.lexeme_char  = ch;
    r.char_valid   = valid;
    r.token_done   = done;
    r.token_kind   = kind;
    r.start_line   = line;
    r.start_column = col;
    r.error_code   = err;
    return r;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - CASE_GAP : c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [1:0] k);
    logic [3:0] l;
    unique case (k)
      KW_CRISP:     l = 4'd5;
      KW_MAINCRISP: l = 4'd9;
      KW_BITE:      l = 4'd4;
      default:      l = 4'd4;
    endcase
    return l;
  endfunction

  // keyword text, first character in the top byte
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [3:0] i);
    logic [71:0] s;
    logic [71:0] sh;
    unique case (k)
      KW_CRISP:     s = {"CRISP", 32'h0};
      KW_MAINCRISP: s = "MAINCRISP";
      KW_BITE:      s = {"BITE", 40'h0};
      default:      s = {"ENDL", 40'h0};
    endcase
    sh = s << {i, 3'b000};
    return sh[71:64];
  endfunction

  // keywords ruled out by an upper-cased character at a lexeme position
  function automatic logic [3:0] kw_miss(input logic [LEX_W-1:0] len, input logic [7:0] up);
    logic [3:0] m;
    for (int k = 0; k < 4; k++) begin
      m[k] = (len >= LEX_W'(kw_len(2'(k)))) || (kw_char(2'(k), len[3:0]) != up);
    end
    return m;
  endfunction

  // lowest surviving keyword of full length, else plain identifier
  function automatic logic [3:0] ident_kind(input logic [3:0] cand, input logic [LEX_W-1:0] len);
    logic [3:0] kind;
    kind = KIND_IDENT;
    for (int k = 3; k >= 0; k--) begin
      if (cand[k] && (len == LEX_W'(kw_len(2'(k))))) begin
        kind = KIND_KW_BASE + 4'(k);
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

// ===== sv/source_lexer_nested_comments.sv =====
// top level of the nested-comment source lexer
// The lexer takes one source request per clock (a byte, an end-of-line mark or an
// end-of-program mark) and returns token results on a separate valid/ready
// channel. A request is taken in the cycle it arrives as long as the four-entry
// bundle queue is not full; its results are queued and then registered at the
// output. Most requests cause zero or one result, a few cause two (a closed
// identifier or lone bar followed by a new token), and the back end drains one
// result per clock unless tok_ready stalls it, so the sustained rate is one request
// per cycle with the queue soaking up the occasional second result. Identifier and string
// characters come out one per result, followed by a closing result with kind and
// start position. After an error or past-end report the block ignores further
// requests until reset. There is no memory and no clearing pass after reset.
`default_nettype none

module source_lexer_nested_comments import slnc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_ready,
  input  item_t   req,
  output logic    tok_valid,
  input  logic    tok_ready,
  output result_t tok
);

  bundle_t       wr_bundle, head;
  queue_status_t q_status;
  front_status_t fr_status;
  logic          pop;

  slnc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_status  (q_status),
    .bundle    (wr_bundle),
    .status    (fr_status)
  );

  slnc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (fr_status.push),
    .wr     (wr_bundle),
    .pop    (pop),
    .rd     (head),
    .status (q_status)
  );

  slnc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_status.empty),
    .pop       (pop),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok)
  );

  // no bundle is written into a full queue
  assert property (@(posedge clk) disable iff (rst) q_status.full |-> !fr_status.push)
    else $error("bundle pushed into full queue");

  // a halted scanner produces nothing more
  assert property (@(posedge clk) disable iff (rst) fr_status.halted |-> !fr_status.push)
    else $error("result produced after halt");

  // halting always comes with the error result that caused it
  assert property (@(posedge clk) disable iff (rst) $rose(fr_status.halted) |-> $past(fr_status.push))
    else $error("halt without error result");

  // error results are closing results of unknown kind with no character
  assert property (@(posedge clk) disable iff (rst)
      tok_valid && (tok.error_code != ERR_NONE) |->
      tok.token_done && (tok.token_kind == KIND_UNKNOWN) && !tok.char_valid)
    else $error("malformed error result");

  // a result that does not close a token carries an identifier or string character
  assert property (@(posedge clk) disable iff (rst)
      tok_valid && !tok.token_done |->
      tok.char_valid && ((tok.token_kind == KIND_IDENT) || (tok.token_kind == KIND_STRING)))
    else $error("character result of wrong kind");

endmodule

`default_nettype wire

// ===== sv/slnc_front.sv =====
// front end: accepts characters, tracks position and scan mode, builds result bundles
`default_nettype none

module slnc_front import slnc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  item_t         req,
  input  queue_status_t q_status,
  output bundle_t       bundle,
  output front_status_t status
);

  logic              accept;
  logic              ev_eop, ev_eol, ev_char;
  logic [7:0]        c, up;
  logic              esc_ok;

  mode_t             mode, mode_next;
  logic [DEPTH_W-1:0] depth, depth_next, depth_dec;
  logic              depth_max;
  logic [3:0]        cand, cand_next;
  logic [LEX_W-1:0]  len, len_next;
  logic [LINE_W-1:0] line_cnt, line_next, tok_line, tok_line_next;
  logic [COL_W-1:0]  col_cnt, col_next, tok_col, tok_col_next;
  logic              halted, halted_next;

  mode_t             idle_mode;
  logic              idle_emit, idle_tok_set;
  result_t           idle_res;
  logic [LEX_W-1:0]  idle_len;
  logic [3:0]        idle_cand;

  logic              add_fail;
  logic [3:0]        add_cand;
  logic [LEX_W-1:0]  add_len;

  result_t           r0, r1;
  logic [1:0]        n;
  logic              use_idle, pre_n;

  // single-character punctuation decode
  function automatic logic [3:0] punct_kind(input logic [7:0] ch);
    logic [3:0] k;
    unique case (ch)
      CH_COMMA:  k = KIND_COMMA;
      CH_DOT:    k = KIND_DOT;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_PLUS:   k = KIND_PLUS;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  // handshake and event decode
  assign req_ready = !q_status.full;
  assign accept    = req_valid && req_ready;
  assign ev_eop    = req.end_of_program;
  assign ev_eol    = !req.end_of_program && req.end_of_line;
  assign ev_char   = !req.end_of_program && !req.end_of_line;
  assign c         = req.character;
  assign up        = to_upper(req.character);
  assign esc_ok    = (c == CH_LOW_N) || (c == CH_LOW_T) || (c == CH_LOW_B) ||
                     (c == CH_LOW_R) || (c == CH_BSLASH) || (c == CH_COMMA) ||
                     (c == CH_QUOTE);

  // comment depth helpers
  assign depth_max = depth >= DEPTH_W'(MAX_COMMENT_DEPTH);
  assign depth_dec = (depth != '0) ? depth - DEPTH_W'(1) : '0;

  // lexeme append helpers
  assign add_fail = len >= LEX_W'(MAX_LEXEME);
  assign add_cand = cand & ~kw_miss(len, up);
  assign add_len  = len + LEX_W'(1);

  // saturating position counters, frozen once halted
  always_comb begin
    line_next = line_cnt;
    col_next  = col_cnt;
    if (!halted) begin
      if (ev_eol) begin
        if (line_cnt != '1) line_next = line_cnt + LINE_W'(1);
        col_next = '0;
      end else if (ev_char && col_cnt != '1) begin
        col_next = col_cnt + COL_W'(1);
      end
    end
  end

  // what the block does with an item when it sits between tokens
  always_comb begin
    idle_mode    = M_IDLE;
    idle_emit    = 1'b0;
    idle_res     = '0;
    idle_tok_set = 1'b0;
    idle_len     = len;
    idle_cand    = cand;
    if (ev_eop) begin
      idle_mode = M_ENDED;
      idle_emit = 1'b1;
      idle_res  = mk_result(CH_NUL, 1'b0, 1'b1, KIND_END, line_cnt, col_cnt, ERR_NONE);
    end else if (!ev_eol && c != CH_SPACE && c != CH_TAB) begin
      idle_tok_set = 1'b1;
      idle_len     = '0;
      if (c == CH_BAR) begin
        idle_mode = M_PIPE;
      end else if (is_alpha(c)) begin
        idle_mode = M_IDENT;
        idle_cand = ~kw_miss('0, up);
        idle_len  = LEX_W'(1);
        idle_emit = 1'b1;
        idle_res  = mk_result(c, 1'b1, 1'b0, KIND_IDENT, line_cnt, col_cnt, ERR_NONE);
      end else if (c == CH_QUOTE) begin
        idle_mode = M_STRING;
      end else begin
        idle_emit = 1'b1;
        idle_res  = mk_result(c, 1'b1, 1'b1, punct_kind(c), line_cnt, col_cnt, ERR_NONE);
      end
    end
  end

  // next scan mode and halt flag
  always_comb begin
    mode_next   = mode;
    halted_next = halted;
    if (!halted) begin
      unique case (mode)
        M_ENDED: halted_next = 1'b1;
        M_PIPE: begin
          if (ev_char && c == CH_BAR)         mode_next = M_LINE;
          else if (ev_char && c == CH_LBRACK) mode_next = M_BLOCK;
          else                                mode_next = idle_mode;
        end
        M_LINE: begin
          if (ev_eop)      mode_next = idle_mode;
          else if (ev_eol) mode_next = M_IDLE;
        end
        M_BLOCK, M_BLOCK_PIPE, M_BLOCK_BRACKET: begin
          if (ev_eop) begin
            halted_next = 1'b1;
          end else if (ev_eol) begin
            mode_next = M_BLOCK;
          end else if (mode == M_BLOCK_PIPE && c == CH_LBRACK) begin
            if (depth_max) halted_next = 1'b1;
            else           mode_next = M_BLOCK;
          end else if (mode == M_BLOCK_BRACKET && c == CH_BAR) begin
            mode_next = (depth_dec != '0) ? M_BLOCK : M_IDLE;
          end else if (c == CH_BAR) begin
            mode_next = M_BLOCK_PIPE;
          end else if (c == CH_RBRACK) begin
            mode_next = M_BLOCK_BRACKET;
          end else begin
            mode_next = M_BLOCK;
          end
        end
        M_IDENT: begin
          if (ev_char && is_ident_char(c)) begin
            if (add_fail) halted_next = 1'b1;
          end else begin
            mode_next = idle_mode;
          end
        end
        M_STRING: begin
          if (!ev_char) begin
            halted_next = 1'b1;
          end else if (c == CH_QUOTE) begin
            mode_next = M_IDLE;
          end else begin
            if (c == CH_BSLASH) mode_next = M_STRING_ESC;
            if (add_fail) halted_next = 1'b1;
          end
        end
        M_STRING_ESC: begin
          if (ev_char && esc_ok) begin
            mode_next = M_STRING;
            if (add_fail) halted_next = 1'b1;
          end else begin
            halted_next = 1'b1;
          end
        end
        default: mode_next = idle_mode;
      endcase
    end
  end

  // results and token data
  always_comb begin
    depth_next    = depth;
    cand_next     = cand;
    len_next      = len;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    r0            = '0;
    r1            = '0;
    n             = 2'd0;
    use_idle      = 1'b0;
    pre_n         = 1'b0;
    if (!halted) begin
      unique case (mode)
        M_ENDED: begin
          r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, line_cnt, col_cnt, ERR_PAST_END);
          n  = 2'd1;
        end
        M_PIPE: begin
          if (ev_char && c == CH_LBRACK) begin
            depth_next = DEPTH_W'(1);
          end else if (!(ev_char && c == CH_BAR)) begin
            // lone bar becomes an unknown token at its own position
            r0 = mk_result(CH_BAR, 1'b1, 1'b1, KIND_UNKNOWN, tok_line, tok_col, ERR_NONE);
            pre_n    = 1'b1;
            use_idle = 1'b1;
          end
        end
        M_LINE: begin
          if (ev_eop) use_idle = 1'b1;
        end
        M_BLOCK, M_BLOCK_PIPE, M_BLOCK_BRACKET: begin
          if (ev_eop) begin
            r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, line_cnt, col_cnt,
                           ERR_OPEN_COMMENT);
            n  = 2'd1;
          end else if (ev_char && mode == M_BLOCK_PIPE && c == CH_LBRACK) begin
            if (depth_max) begin
              r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, line_cnt, col_cnt,
                             ERR_TOO_DEEP);
              n  = 2'd1;
            end else begin
              depth_next = depth + DEPTH_W'(1);
            end
          end else if (ev_char && mode == M_BLOCK_BRACKET && c == CH_BAR) begin
            depth_next = depth_dec;
          end
        end
        M_IDENT: begin
          if (ev_char && is_ident_char(c)) begin
            n = 2'd1;
            if (add_fail) begin
              r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, tok_line, tok_col,
                             ERR_TOO_LONG);
            end else begin
              cand_next = add_cand;
              len_next  = add_len;
              r0 = mk_result(c, 1'b1, 1'b0, KIND_IDENT, tok_line, tok_col, ERR_NONE);
            end
          end else begin
            r0 = mk_result(CH_NUL, 1'b0, 1'b1, ident_kind(cand, len), tok_line, tok_col,
                           ERR_NONE);
            pre_n    = 1'b1;
            use_idle = 1'b1;
          end
        end
        M_STRING, M_STRING_ESC: begin
          n = 2'd1;
          if (mode == M_STRING && !ev_char) begin
            r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, tok_line, tok_col,
                           ERR_OPEN_STRING);
          end else if (mode == M_STRING_ESC && !(ev_char && esc_ok)) begin
            r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, tok_line, tok_col,
                           ERR_BAD_ESCAPE);
          end else if (mode == M_STRING && c == CH_QUOTE) begin
            r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_STRING, tok_line, tok_col, ERR_NONE);
          end else if (add_fail) begin
            r0 = mk_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, tok_line, tok_col,
                           ERR_TOO_LONG);
          end else begin
            len_next = add_len;
            r0 = mk_result(c, 1'b1, 1'b0, KIND_STRING, tok_line, tok_col, ERR_NONE);
          end
        end
        default: use_idle = 1'b1;
      endcase

      // fold in the between-tokens handling after a closed token
      if (use_idle) begin
        if (idle_tok_set) begin
          tok_line_next = line_cnt;
          tok_col_next  = col_cnt;
        end
        len_next  = idle_len;
        cand_next = idle_cand;
        if (idle_emit) begin
          if (pre_n) r1 = idle_res;
          else       r0 = idle_res;
        end
        n = {1'b0, pre_n} + {1'b0, idle_emit};
      end
    end
  end

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= M_IDLE;
      depth    <= '0;
      cand     <= 4'hF;
      len      <= '0;
      line_cnt <= LINE_W'(1);
      col_cnt  <= '0;
      tok_line <= '0;
      tok_col  <= '0;
      halted   <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      depth    <= depth_next;
      cand     <= cand_next;
      len      <= len_next;
      line_cnt <= line_next;
      col_cnt  <= col_next;
      tok_line <= tok_line_next;
      tok_col  <= tok_col_next;
      halted   <= halted_next;
    end
  end

  // bundle toward the queue
  assign bundle.two    = n[1];
  assign bundle.first  = r0;
  assign bundle.second = r1;
  assign status.push   = accept && (n != 2'd0);
  assign status.halted = halted;

endmodule

`default_nettype wire

// ===== sv/slnc_queue.sv =====
// small register queue of result bundles between front and back
`default_nettype none

module slnc_queue import slnc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bundle_t       wr,
  input  logic          pop,
  output bundle_t       rd,
  output queue_status_t status
);

  bundle_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rd           = entries[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/slnc_back.sv =====
// back end: unpacks bundles into single results behind an output register
`default_nettype none

module slnc_back import slnc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  bundle_t head,
  input  logic    q_empty,
  output logic    pop,
  output logic    tok_valid,
  input  logic    tok_ready,
  output result_t tok
);

  logic slot;
  logic load;

  // take the next result whenever the output register is free or draining
  assign load = !q_empty && (!tok_valid || tok_ready);
  assign pop  = load && (slot || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      slot      <= 1'b0;
    end else begin
      if (load)           tok_valid <= 1'b1;
      else if (tok_ready) tok_valid <= 1'b0;
      if (load)           slot <= head.two && !slot;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) tok <= slot ? head.second : head.first;
  end

endmodule

`default_nettype wire

// ===== sim/source_lexer_nested_comments_tb.sv =====
// testbench for the nested-comment source lexer: random programs checked against a token predictor
module source_lexer_nested_comments_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slnc_pkg::*;

  localparam int RANDOM_ITEMS   = 180;
  localparam int MAX_GAP        = 17;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct packed {
    item_t      it;
    logic [4:0] gap;
  } source_entry_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    req_valid = 1'b0;
  logic    req_ready;
  item_t   req = '0;
  logic    tok_valid;
  logic    tok_ready = 1'b0;
  result_t tok;

  source_lexer_nested_comments uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok(tok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // stimulus and expectation stores
  source_entry_t source_items[$];
  result_t       expected_tokens[$];
  source_entry_t next_entry;
  result_t       want_token;
  bit            src_calm = 1'b0;
  bit            sink_calm = 1'b0;
  int            fail_count = 0;
  int            items_taken = 0;
  int            total_items = 0;
  int            hold_count = 0;
  int            stall_left = 0;
  int            stall_draw = 0;
  int            quiet_cycles = 0;

  string      kw_names[4] = '{"CRISP", "MAINCRISP", "BITE", "ENDL"};
  logic [7:0] punct_set[7] = '{CH_COMMA, CH_DOT, CH_LBRACE, CH_RBRACE,
                               CH_LPAREN, CH_RPAREN, CH_PLUS};
  logic [7:0] escape_set[7] = '{CH_LOW_N, CH_LOW_T, CH_LOW_B, CH_LOW_R,
                                CH_BSLASH, CH_COMMA, CH_QUOTE};

  // scanner state as the predictor sees it
  mode_t       scan_state = M_IDLE;
  int          nest_depth = 0;
  logic [3:0]  kw_alive = 4'hF;
  int          lex_len = 0;
  logic [15:0] cur_line = 16'd1;
  logic [7:0]  cur_col = 8'd0;
  logic [15:0] tok_start_line = 16'd0;
  logic [7:0]  tok_start_col = 8'd0;
  bit          stopped = 1'b0;

  function automatic logic letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic escape_ok(logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 7; i++) begin
      if (c == escape_set[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic void push_result(logic [7:0] ch, logic valid, logic done,
                                      logic [3:0] kind, logic [15:0] line,
                                      logic [7:0] col, logic [2:0] err);
    result_t r;
    r.lexeme_char  = ch;
    r.char_valid   = valid;
    r.token_done   = done;
    r.token_kind   = kind;
    r.start_line   = line;
    r.start_column = col;
    r.error_code   = err;
    expected_tokens.push_back(r);
  endfunction

  function automatic void lex_fail(logic [15:0] line, logic [7:0] col, logic [2:0] err);
    stopped = 1'b1;
    push_result(CH_NUL, 1'b0, 1'b1, KIND_UNKNOWN, line, col, err);
  endfunction

  // one lexeme character, with keyword tracking for identifiers
  function automatic void append_char(logic [7:0] c, logic [3:0] kind);
    logic [7:0] up;
    if (lex_len >= MAX_LEXEME) begin
      lex_fail(tok_start_line, tok_start_col, ERR_TOO_LONG);
      return;
    end
    if (kind == KIND_IDENT) begin
      up = (c >= "a" && c <= "z") ? c - CASE_GAP : c;
      for (int k = 0; k < 4; k++) begin
        if (lex_len >= kw_names[k].len() || kw_names[k][lex_len] != up) kw_alive[k] = 1'b0;
      end
    end
    lex_len++;
    push_result(c, 1'b1, 1'b0, kind, tok_start_line, tok_start_col, ERR_NONE);
  endfunction

  // item seen between tokens
  function automatic void start_token(logic eop, logic eol, logic [7:0] c,
                                      logic [15:0] line, logic [7:0] col);
    logic [3:0] kind;
    scan_state = M_IDLE;
    if (eop) begin
      scan_state = M_ENDED;
      push_result(CH_NUL, 1'b0, 1'b1, KIND_END, line, col, ERR_NONE);
      return;
    end
    if (eol || c == CH_SPACE || c == CH_TAB) return;
    tok_start_line = line;
    tok_start_col  = col;
    lex_len        = 0;
    if (c == CH_BAR) begin
      scan_state = M_PIPE;
      return;
    end
    if (letter(c)) begin
      scan_state = M_IDENT;
      kw_alive   = 4'hF;
      append_char(c, KIND_IDENT);
      return;
    end
    if (c == CH_QUOTE) begin
      scan_state = M_STRING;
      return;
    end
    case (c)
      CH_COMMA:  kind = KIND_COMMA;
      CH_DOT:    kind = KIND_DOT;
      CH_LBRACE: kind = KIND_LBRACE;
      CH_RBRACE: kind = KIND_RBRACE;
      CH_LPAREN: kind = KIND_LPAREN;
      CH_RPAREN: kind = KIND_RPAREN;
      CH_PLUS:   kind = KIND_PLUS;
      default:   kind = KIND_UNKNOWN;
    endcase
    push_result(c, 1'b1, 1'b1, kind, line, col, ERR_NONE);
  endfunction

  // expected results of one accepted request
  function automatic void scan_item(item_t it);
    logic        eop;
    logic        eol;
    logic        plain;
    logic [7:0]  c;
    logic [15:0] line;
    logic [7:0]  col;
    logic [3:0]  kind;
    eop   = it.end_of_program;
    eol   = it.end_of_line && !eop;
    plain = !eop && !eol;
    c     = it.character;
    line  = cur_line;
    col   = cur_col;
    if (stopped) return;
    // position counters saturate
    if (eol) begin
      if (cur_line != 16'hFFFF) cur_line++;
      cur_col = 8'd0;
    end else if (plain && cur_col != 8'hFF) begin
      cur_col++;
    end
    case (scan_state)
      M_ENDED: lex_fail(line, col, ERR_PAST_END);
      M_PIPE: begin
        if (plain && c == CH_BAR) begin
          scan_state = M_LINE;
        end else if (plain && c == CH_LBRACK) begin
          nest_depth = 1;
          scan_state = M_BLOCK;
        end else begin
          // lone bar reported late, then the item starts over
          push_result(CH_BAR, 1'b1, 1'b1, KIND_UNKNOWN, tok_start_line, tok_start_col,
                      ERR_NONE);
          start_token(eop, eol, c, line, col);
        end
      end
      M_LINE: begin
        if (eop) start_token(eop, eol, c, line, col);
        else if (eol) scan_state = M_IDLE;
      end
      M_BLOCK, M_BLOCK_PIPE, M_BLOCK_BRACKET: begin
        if (eop) begin
          lex_fail(line, col, ERR_OPEN_COMMENT);
        end else if (eol) begin
          scan_state = M_BLOCK;
        end else if (scan_state == M_BLOCK_PIPE && c == CH_LBRACK) begin
          if (nest_depth >= MAX_COMMENT_DEPTH) begin
            lex_fail(line, col, ERR_TOO_DEEP);
          end else begin
            nest_depth++;
            scan_state = M_BLOCK;
          end
        end else if (scan_state == M_BLOCK_BRACKET && c == CH_BAR) begin
          if (nest_depth > 0) nest_depth--;
          if (nest_depth != 0) scan_state = M_BLOCK;
          else scan_state = M_IDLE;
        end else if (c == CH_BAR) begin
          scan_state = M_BLOCK_PIPE;
        end else if (c == CH_RBRACK) begin
          scan_state = M_BLOCK_BRACKET;
        end else begin
          scan_state = M_BLOCK;
        end
      end
      M_IDENT: begin
        if (plain && (letter(c) || (c >= "0" && c <= "9") || c == CH_UNDER)) begin
          append_char(c, KIND_IDENT);
        end else begin
          kind = KIND_IDENT;
          for (int k = 3; k >= 0; k--) begin
            if (kw_alive[k] && lex_len == kw_names[k].len()) kind = KIND_KW_BASE + 4'(k);
          end
          push_result(CH_NUL, 1'b0, 1'b1, kind, tok_start_line, tok_start_col, ERR_NONE);
          start_token(eop, eol, c, line, col);
        end
      end
      M_STRING: begin
        if (!plain) begin
          lex_fail(tok_start_line, tok_start_col, ERR_OPEN_STRING);
        end else if (c == CH_QUOTE) begin
          scan_state = M_IDLE;
          push_result(CH_NUL, 1'b0, 1'b1, KIND_STRING, tok_start_line, tok_start_col,
                      ERR_NONE);
        end else begin
          if (c == CH_BSLASH) scan_state = M_STRING_ESC;
          append_char(c, KIND_STRING);
        end
      end
      M_STRING_ESC: begin
        if (plain && escape_ok(c)) begin
          scan_state = M_STRING;
          append_char(c, KIND_STRING);
        end else begin
          lex_fail(tok_start_line, tok_start_col, ERR_BAD_ESCAPE);
        end
      end
      default: start_token(eop, eol, c, line, col);
    endcase
  endfunction

  // program builders
  function automatic void queue_item(logic [7:0] c, logic eol, logic eop);
    source_entry_t e;
    if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
    e.it.character      = c;
    e.it.end_of_line    = eol;
    e.it.end_of_program = eop;
    e.gap = src_calm ? 5'd0 : 5'($urandom_range(0, MAX_GAP));
    source_items.push_back(e);
  endfunction

  function automatic void queue_byte(logic [7:0] c);
    queue_item(c, 1'b0, 1'b0);
  endfunction

  function automatic void queue_eol();
    queue_item(8'($urandom), 1'b1, 1'b0);
  endfunction

  function automatic void queue_eop();
    queue_item(8'($urandom), 1'($urandom), 1'b1);
  endfunction

  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void queue_punct();
    queue_byte(punct_set[$urandom_range(0, 6)]);
  endfunction

  function automatic logic [7:0] random_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] random_word_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0, 1:    c = random_letter();
      2:       c = 8'h30 + 8'($urandom_range(0, 9));
      default: c = CH_UNDER;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] string_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  // comment body byte that cannot open or close a level
  function automatic logic [7:0] comment_byte(logic after_bar);
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CH_BAR || c == CH_RBRACK || (after_bar && c == CH_LBRACK));
    return c;
  endfunction

  function automatic void queue_separator();
    case ($urandom_range(0, 3))
      0:       queue_byte(CH_SPACE);
      1:       queue_byte(CH_TAB);
      2:       queue_eol();
      default: queue_punct();
    endcase
  endfunction

  function automatic void queue_ident(int len);
    queue_byte(random_letter());
    for (int i = 1; i < len; i++) queue_byte(random_word_char());
  endfunction

  // keyword in mixed case, sometimes one short or one long
  function automatic void queue_keyword();
    int         k;
    int         n;
    logic [7:0] c;
    k = $urandom_range(0, 3);
    n = kw_names[k].len();
    case ($urandom_range(0, 3))
      0:       n = n - 1;
      1:       n = n + 1;
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      if (i < kw_names[k].len()) begin
        c = kw_names[k][i];
        if ($urandom_range(0, 1)) c = c + CASE_GAP;
      end else begin
        c = random_word_char();
      end
      queue_byte(c);
    end
  endfunction

  function automatic void queue_string(int len, bit esc_allowed);
    queue_byte(CH_QUOTE);
    for (int i = 0; i < len; i++) begin
      if (esc_allowed && $urandom_range(0, 3) == 0) begin
        queue_byte(CH_BSLASH);
        queue_byte(escape_set[$urandom_range(0, 6)]);
      end else begin
        queue_byte(string_byte());
      end
    end
    queue_byte(CH_QUOTE);
  endfunction

  function automatic void queue_comment_filler();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 3))
        0: queue_byte(comment_byte(1'b0));
        1: queue_eol();
        2: begin
          queue_byte(CH_BAR);
          queue_byte(comment_byte(1'b1));
        end
        default: begin
          queue_byte(CH_RBRACK);
          queue_byte(comment_byte(1'b0));
        end
      endcase
    end
  endfunction

  function automatic void queue_block(int depth);
    for (int i = 0; i < depth; i++) begin
      queue_text("|[");
      queue_comment_filler();
    end
    for (int i = 0; i < depth; i++) begin
      queue_text("]|");
      if (i < depth - 1) queue_comment_filler();
    end
  endfunction

  // well-formed token with random content, or a bit of noise
  function automatic void queue_random_token();
    logic [7:0] c;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        queue_keyword();
        queue_separator();
      end
      3, 4, 5: begin
        queue_ident($urandom_range(1, 8));
        queue_separator();
      end
      6, 7: queue_punct();
      8, 9, 10: queue_string($urandom_range(0, 6), 1'b1);
      11: begin
        do c = 8'($urandom); while (c == CH_QUOTE || c == CH_BAR);
        queue_byte(c);
        queue_separator();
      end
      12: begin
        queue_byte(CH_BAR);
        queue_separator();
      end
      13: begin
        queue_text("||");
        repeat ($urandom_range(0, 6)) queue_byte(8'($urandom));
        queue_eol();
      end
      14, 15: queue_block($urandom_range(1, 3));
      16: begin
        queue_ident($urandom_range(9, 24));
        queue_separator();
      end
      default: queue_separator();
    endcase
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      req        <= '0;
      hold_count <= 0;
    end else begin
      if (req_valid && req_ready) begin
        scan_item(req);
        items_taken <= items_taken + 1;
      end
      if (!req_valid || req_ready) begin
        if (source_items.size() != 0 && hold_count >= source_items[0].gap) begin
          next_entry = source_items.pop_front();
          req_valid  <= 1'b1;
          req        <= next_entry.it;
          hold_count <= 0;
        end else begin
          req_valid <= 1'b0;
          if (source_items.size() != 0) hold_count <= hold_count + 1;
        end
      end
    end
  end

  // token monitor with random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      tok_ready  <= 1'b0;
      stall_left <= 0;
    end else if (tok_valid && tok_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token result with nothing pending: kind %0d line %0d column %0d",
               tok.token_kind, tok.start_line, tok.start_column);
        fail_count++;
      end else begin
        want_token = expected_tokens.pop_front();
        check_field("lexeme_char", want_token.lexeme_char, tok.lexeme_char);
        check_field("char_valid", want_token.char_valid, tok.char_valid);
        check_field("token_done", want_token.token_done, tok.token_done);
        check_field("token_kind", want_token.token_kind, tok.token_kind);
        check_field("start_line", want_token.start_line, tok.start_line);
        check_field("start_column", want_token.start_column, tok.start_column);
        check_field("error_code", want_token.error_code, tok.error_code);
      end
      if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
      stall_draw = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall_draw == 0) begin
        tok_ready <= 1'b1;
      end else begin
        tok_ready  <= 1'b0;
        stall_left <= stall_draw;
      end
    end else if (!tok_ready) begin
      if (stall_left <= 1) tok_ready <= 1'b1;
      else stall_left <= stall_left - 1;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (tok_valid && tok_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         base;
    logic [7:0] c;

    // directed: byte extremes, tab, all punctuation, lone bar, escape, comments
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(CH_TAB);
    for (int i = 0; i < 7; i++) queue_byte(punct_set[i]);
    queue_byte(CH_BAR);
    queue_byte("a");
    queue_byte(CH_SPACE);
    queue_text("\"\\,\"");
    queue_text("|[|[]|]|");
    queue_text("||x");
    queue_eol();

    base = source_items.size();
    while (source_items.size() < base + RANDOM_ITEMS / 2) queue_random_token();

    base = source_items.size();
    while (source_items.size() < base + RANDOM_ITEMS / 2) queue_random_token();

    queue_keyword();
    queue_separator();
    queue_punct();
    queue_eol();
    queue_punct();

    // one stopping case, since the block halts until reset
    case ($urandom_range(0, 4))
      0: begin
        queue_eop();
        queue_punct();
      end
      1: begin
        queue_byte(CH_QUOTE);
        queue_byte(string_byte());
        queue_byte(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: begin
            do c = 8'($urandom); while (escape_ok(c));
            queue_byte(c);
          end
          1:       queue_eol();
          default: queue_eop();
        endcase
      end
      2: begin
        queue_byte(CH_QUOTE);
        queue_byte(string_byte());
        queue_byte(string_byte());
        if ($urandom_range(0, 1)) queue_eol();
        else queue_eop();
      end
      3: begin
        queue_text("|[|[");
        queue_byte(comment_byte(1'b0));
        queue_eop();
      end
      default: begin
        queue_text("||");
        queue_byte(8'($urandom));
        queue_eop();
        queue_byte(8'($urandom));
      end
    endcase
    // ignored once stopped
    repeat (3) queue_item(8'($urandom), 1'($urandom), 1'($urandom));
    queue_item(8'($urandom), 1'($urandom), 1'b1);

    total_items = source_items.size();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (items_taken != total_items) @(posedge clk);
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
